// File: hw/rtl/mmbd_pkg.sv
package mmbd_pkg;

  // Default geometry of the banked stores
  localparam int ROM_BANK_BYTES_DEF = 16384;
  localparam int VRAM_BYTES_DEF     = 8192;
  localparam int CART_BYTES         = 8192;
  localparam int WRAM_BYTES         = 8192;
  // Sprite table, io registers, high ram and interrupt enable share one window
  localparam int SMALL_BYTES        = 512;

  // Inclusive end bounds of the bus regions, ascending
  localparam logic [15:0] END_ROM0   = 16'h3FFF;
  localparam logic [15:0] END_ROMX   = 16'h7FFF;
  localparam logic [15:0] END_VRAM   = 16'h9FFF;
  localparam logic [15:0] END_CART   = 16'hBFFF;
  localparam logic [15:0] END_WRAM   = 16'hDFFF;
  localparam logic [15:0] END_ECHO   = 16'hFDFF;
  localparam logic [15:0] END_SPRITE = 16'hFE9F;
  localparam logic [15:0] END_GAP0   = 16'hFEFF;
  localparam logic [15:0] END_IO     = 16'hFF4B;
  localparam logic [15:0] END_GAP1   = 16'hFF7F;
  localparam logic [15:0] END_HRAM   = 16'hFFFE;

  typedef enum logic [2:0] {
    REQ_READ    = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_INC     = 3'd2,
    REQ_DEC     = 3'd3,
    REQ_ADD     = 3'd4,
    REQ_SUB     = 3'd5,
    REQ_LOAD    = 3'd6,
    REQ_UNKNOWN = 3'd7
  } req_t;

  typedef enum logic [3:0] {
    RGN_ROM0   = 4'd0,
    RGN_ROMX   = 4'd1,
    RGN_VRAM   = 4'd2,
    RGN_CART   = 4'd3,
    RGN_WRAM   = 4'd4,
    RGN_ECHO   = 4'd5,
    RGN_SPRITE = 4'd6,
    RGN_GAP0   = 4'd7,
    RGN_IO     = 4'd8,
    RGN_GAP1   = 4'd9,
    RGN_HRAM   = 4'd10,
    RGN_IE     = 4'd11
  } region_t;

  localparam int REGION_LAST = 11;

  // Decoder result for one bus address
  typedef struct packed {
    region_t region;
    logic    has_cell;  // address maps to a stored byte
    logic    is_rom;    // byte lives in the ROM store
  } dec_t;

endpackage

// File: hw/rtl/mmbd_decode.sv
module mmbd_decode #(
  parameter int VRAM_BYTES = mmbd_pkg::VRAM_BYTES_DEF,
  parameter int RAM_AW     = 15
) (
  input  logic [15:0]        addr,
  output mmbd_pkg::dec_t     dec,
  output logic [RAM_AW-1:0]  ram_idx
);

  localparam int VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int CART_AW    = $clog2(mmbd_pkg::CART_BYTES);
  localparam int WRAM_AW    = $clog2(mmbd_pkg::WRAM_BYTES);
  localparam int SMALL_AW   = $clog2(mmbd_pkg::SMALL_BYTES);
  localparam int CART_BASE  = VRAM_BYTES;
  localparam int WRAM_BASE  = CART_BASE + mmbd_pkg::CART_BYTES;
  localparam int SMALL_BASE = WRAM_BASE + mmbd_pkg::WRAM_BYTES;

  logic [SMALL_AW-1:0] small_off;

  // Region by ascending end bounds
  always_comb begin
    dec = '0;
    priority if (addr <= mmbd_pkg::END_ROM0) begin
      dec.region = mmbd_pkg::RGN_ROM0;
    end else if (addr <= mmbd_pkg::END_ROMX) begin
      dec.region = mmbd_pkg::RGN_ROMX;
    end else if (addr <= mmbd_pkg::END_VRAM) begin
      dec.region = mmbd_pkg::RGN_VRAM;
    end else if (addr <= mmbd_pkg::END_CART) begin
      dec.region = mmbd_pkg::RGN_CART;
    end else if (addr <= mmbd_pkg::END_WRAM) begin
      dec.region = mmbd_pkg::RGN_WRAM;
    end else if (addr <= mmbd_pkg::END_ECHO) begin
      dec.region = mmbd_pkg::RGN_ECHO;
    end else if (addr <= mmbd_pkg::END_SPRITE) begin
      dec.region = mmbd_pkg::RGN_SPRITE;
    end else if (addr <= mmbd_pkg::END_GAP0) begin
      dec.region = mmbd_pkg::RGN_GAP0;
    end else if (addr <= mmbd_pkg::END_IO) begin
      dec.region = mmbd_pkg::RGN_IO;
    end else if (addr <= mmbd_pkg::END_GAP1) begin
      dec.region = mmbd_pkg::RGN_GAP1;
    end else if (addr <= mmbd_pkg::END_HRAM) begin
      dec.region = mmbd_pkg::RGN_HRAM;
    end else begin
      dec.region = mmbd_pkg::RGN_IE;
    end
    dec.has_cell = (dec.region != mmbd_pkg::RGN_GAP0) && (dec.region != mmbd_pkg::RGN_GAP1);
    dec.is_rom   = (dec.region == mmbd_pkg::RGN_ROM0) || (dec.region == mmbd_pkg::RGN_ROMX);
  end

  // Small window: sprites low half, io at 256, high ram and irq enable at 384
  always_comb begin
    small_off = '0;
    unique case (dec.region)
      mmbd_pkg::RGN_SPRITE: small_off = {1'b0, addr[7:0]};
      mmbd_pkg::RGN_IO:     small_off = {2'b10, addr[6:0]};
      default:              small_off = {2'b11, addr[6:0]};
    endcase
  end

  // Index into the shared RAM store; echo aliases work ram
  always_comb begin
    unique case (dec.region)
      mmbd_pkg::RGN_VRAM: ram_idx = RAM_AW'(addr[VRAM_AW-1:0]);
      mmbd_pkg::RGN_CART: ram_idx = RAM_AW'(CART_BASE) + RAM_AW'(addr[CART_AW-1:0]);
      mmbd_pkg::RGN_WRAM,
      mmbd_pkg::RGN_ECHO: ram_idx = RAM_AW'(WRAM_BASE) + RAM_AW'(addr[WRAM_AW-1:0]);
      default:            ram_idx = RAM_AW'(SMALL_BASE) + RAM_AW'(small_off);
    endcase
  end

endmodule

// File: hw/rtl/mmbd_rom_mem.sv
module mmbd_rom_mem #(
  parameter int ROM_BANK_BYTES = mmbd_pkg::ROM_BANK_BYTES_DEF,
  parameter int ROM_IW         = $clog2(ROM_BANK_BYTES) + 1
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ROM_IW-1:0] raddr,
  output logic [7:0]        rdata,
  input  logic              we,
  input  logic [ROM_IW-1:0] waddr,
  input  logic [7:0]        wdata
);

  localparam int DEPTH = 2 * ROM_BANK_BYTES;

  logic [7:0] mem [DEPTH];

  // Both banks in one store, bank select is the top index bit
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mmbd_ram_mem.sv
module mmbd_ram_mem #(
  parameter int DEPTH = 25088,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  output logic          busy
);

  logic [7:0]    mem [DEPTH];
  logic          busy_r, busy_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  // Clearing sweep after reset, one entry per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + AW'(1);
      if (cnt_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage: read returns the value before a same-cycle write
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[cnt_r] <= 8'h00;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign busy = busy_r;

endmodule

// File: hw/rtl/memory_map_bus_decoder_core.sv
// Byte-wide memory map of a handheld console bus.
// Input stream (in_*): one request per transfer, tdata = req_type, address, value.
// Output stream (out_*): one result per request, tdata = read_data, region, rejected,
// delivered in request order.
// A request is registered into stage 1 at its transfer, where the memory read is
// issued; stage 1 modifies and writes back, and the result is loaded into the output
// register when stage 1 advances. Throughput is one request per cycle while the
// output is not stalled, set by the single read and write port of the RAM store; a
// write-back to the entry read by the next request is forwarded, so back-to-back
// read-modify-writes on one byte run at full rate. ROM loads write at acceptance.
// Reset: control state clears, then a sweep zeroes the RAM store (video, cart,
// work ram and the small register window). in_tready stays low during the sweep.
// ROM content is undefined until loaded.
// Stall: while out_tready is low the result holds in the output register, one
// more request is read and parked, and in_tready then drops until the output
// drains.
module memory_map_bus_decoder_core #(
  parameter int ROM_BANK_BYTES = mmbd_pkg::ROM_BANK_BYTES_DEF,
  parameter int VRAM_BYTES     = mmbd_pkg::VRAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [2:0] req_type, [18:3] address, [26:19] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [11:8] region, [12] rejected
);

  localparam int ROM_IW    = $clog2(ROM_BANK_BYTES) + 1;
  localparam int RAM_DEPTH = VRAM_BYTES + mmbd_pkg::CART_BYTES + mmbd_pkg::WRAM_BYTES
                             + mmbd_pkg::SMALL_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Request fields
  mmbd_pkg::req_t req_op;
  logic [15:0]    req_addr;
  logic [7:0]     req_val;

  assign req_op   = mmbd_pkg::req_t'(in_tdata[2:0]);
  assign req_addr = in_tdata[18:3];
  assign req_val  = in_tdata[26:19];

  mmbd_pkg::dec_t    dec;
  logic [RAM_AW-1:0] dec_ram_idx;

  mmbd_decode #(
    .VRAM_BYTES (VRAM_BYTES),
    .RAM_AW     (RAM_AW)
  ) u_decode (
    .addr    (req_addr),
    .dec     (dec),
    .ram_idx (dec_ram_idx)
  );

  // Stage 1 and output registers
  logic                s1_v_r;
  mmbd_pkg::req_t      s1_op_r;
  logic [7:0]          s1_val_r;
  mmbd_pkg::region_t   s1_region_r;
  logic                s1_rej_r;
  logic                s1_src_rom_r;
  logic                s1_src_ram_r;
  logic                s1_wr_r;
  logic [RAM_AW-1:0]   s1_idx_r;

  logic                out_valid_r;
  logic [7:0]          out_data_r;
  mmbd_pkg::region_t   out_region_r;
  logic                out_rej_r;

  logic                fwd_v_r;
  logic [RAM_AW-1:0]   fwd_idx_r;
  logic [7:0]          fwd_data_r;

  logic                ram_busy;
  logic [7:0]          rom_rdata;
  logic [7:0]          ram_rdata;

  logic                s1_adv;
  logic                in_fire;
  logic                is_read, is_load, is_mod;
  logic                rom_we, rom_re, ram_re, ram_we;
  logic [7:0]          cur_byte, new_byte, s1_data;
  mmbd_pkg::region_t   s0_region;
  logic                s0_rej;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !ram_busy && (!s1_v_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  // Stage 0: classify request, issue memory reads and ROM load writes
  assign is_read = (req_op == mmbd_pkg::REQ_READ);
  assign is_load = (req_op == mmbd_pkg::REQ_LOAD);
  assign is_mod  = (req_op == mmbd_pkg::REQ_WRITE) || (req_op == mmbd_pkg::REQ_INC) ||
                   (req_op == mmbd_pkg::REQ_DEC)   || (req_op == mmbd_pkg::REQ_ADD) ||
                   (req_op == mmbd_pkg::REQ_SUB);

  assign rom_we = in_fire && is_load;
  assign rom_re = in_fire && is_read && dec.is_rom;
  assign ram_re = in_fire && dec.has_cell && !dec.is_rom && (is_read || is_mod);

  always_comb begin
    if (is_load) begin
      s0_region = req_addr[ROM_IW-1] ? mmbd_pkg::RGN_ROMX : mmbd_pkg::RGN_ROM0;
      s0_rej    = 1'b0;
    end else if (is_read) begin
      s0_region = dec.region;
      s0_rej    = !dec.has_cell;
    end else begin
      s0_region = dec.region;
      s0_rej    = !(is_mod && dec.has_cell && !dec.is_rom);
    end
  end

  mmbd_rom_mem #(
    .ROM_BANK_BYTES (ROM_BANK_BYTES),
    .ROM_IW         (ROM_IW)
  ) u_rom (
    .clk   (clk),
    .re    (rom_re),
    .raddr (req_addr[ROM_IW-1:0]),
    .rdata (rom_rdata),
    .we    (rom_we),
    .waddr (req_addr[ROM_IW-1:0]),
    .wdata (req_val)
  );

  mmbd_ram_mem #(
    .DEPTH (RAM_DEPTH),
    .AW    (RAM_AW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (ram_re),
    .raddr (dec_ram_idx),
    .rdata (ram_rdata),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (new_byte),
    .busy  (ram_busy)
  );

  // Stage 1: forward the last write-back, modify, write back
  assign cur_byte = (fwd_v_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : ram_rdata;

  always_comb begin
    unique case (s1_op_r)
      mmbd_pkg::REQ_WRITE: new_byte = s1_val_r;
      mmbd_pkg::REQ_INC:   new_byte = cur_byte + 8'd1;
      mmbd_pkg::REQ_DEC:   new_byte = cur_byte - 8'd1;
      mmbd_pkg::REQ_ADD:   new_byte = cur_byte + s1_val_r;
      mmbd_pkg::REQ_SUB:   new_byte = cur_byte - s1_val_r;
      default:             new_byte = cur_byte;
    endcase
  end

  assign ram_we  = s1_v_r && s1_adv && s1_wr_r;
  assign s1_data = s1_src_rom_r ? rom_rdata : (s1_src_ram_r ? cur_byte : 8'h00);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_v_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_v_r;
      end
      if (ram_we) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= req_op;
      s1_val_r     <= req_val;
      s1_region_r  <= s0_region;
      s1_rej_r     <= s0_rej;
      s1_src_rom_r <= is_read && dec.is_rom;
      s1_src_ram_r <= is_read && dec.has_cell && !dec.is_rom;
      s1_wr_r      <= is_mod && dec.has_cell && !dec.is_rom;
      s1_idx_r     <= dec_ram_idx;
    end
    if (ram_we) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= new_byte;
    end
    if (s1_adv && s1_v_r) begin
      out_data_r   <= s1_data;
      out_region_r <= s1_region_r;
      out_rej_r    <= s1_rej_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_rej_r, out_region_r, out_data_r};

endmodule

// File: hw/rtl/mmbd_checker.sv
module mmbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Region code stays within the map
  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:8] <= 4'(mmbd_pkg::REGION_LAST))
    else $error("region code out of range");

  // Unused regions are always rejected
  a_gap_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:8] == mmbd_pkg::RGN_GAP0 ||
                   out_tdata[11:8] == mmbd_pkg::RGN_GAP1) |-> out_tdata[12])
    else $error("unused region not rejected");

  // A rejected request returns no data
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[7:0] == 8'h00)
    else $error("rejected request returned data");

  // An accepted request is followed by a waiting result, checked after stage 1 and the output register
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("no result after accepted request");

endmodule

bind memory_map_bus_decoder_core mmbd_checker u_mmbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
